// ===== rtl/core/frs_pkg.sv =====
package frs_pkg;

    localparam int COEF_W  = 32;
    localparam int X_W     = 16;
    localparam int Y_W     = 24;
    localparam int Q_SHIFT = 24;
    localparam int IDX_W   = 4;

    // Exact sum of the three products: 32x24 products need 56 bits, plus two of growth
    localparam int ACC_W   = COEF_W + Y_W + 2;
    // Width after dropping the fraction bits
    localparam int RND_W   = ACC_W - Q_SHIFT;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [X_W-1:0]    smp_in_t;
    typedef logic signed [Y_W-1:0]    smp_out_t;

    typedef struct packed {
        smp_out_t sample;
        logic     clipped;
    } frs_result_t;

    localparam logic [IDX_W-1:0] REG_INIT_A    = 4'd0;
    localparam logic [IDX_W-1:0] REG_INIT_B    = 4'd1;
    localparam logic [IDX_W-1:0] REG_INIT_C    = 4'd2;
    localparam logic [IDX_W-1:0] REG_STEP_A    = 4'd3;
    localparam logic [IDX_W-1:0] REG_STEP_B    = 4'd4;
    localparam logic [IDX_W-1:0] REG_STEP_C    = 4'd5;
    localparam logic [IDX_W-1:0] REG_ANTI_MODE = 4'd6;
    localparam logic [IDX_W-1:0] REG_RAMP_ON   = 4'd7;

    localparam coef_t INIT_A_RST = 32'sd16777216;  // 1.0 in Q8.24

    localparam smp_out_t OUT_MAX = 24'sh7FFFFF;
    localparam smp_out_t OUT_MIN = 24'sh800000;

endpackage

// ===== rtl/core/frs_datapath.sv =====
module frs_datapath (
    input  frs_pkg::coef_t      coef_a,
    input  frs_pkg::coef_t      coef_b,
    input  frs_pkg::coef_t      coef_c,
    input  frs_pkg::smp_in_t    x,
    input  frs_pkg::smp_out_t   h1,
    input  frs_pkg::smp_out_t   h2,
    output frs_pkg::frs_result_t res
);
    import frs_pkg::*;

    logic signed [COEF_W+X_W-1:0] prod_a;
    logic signed [COEF_W+Y_W-1:0] prod_b;
    logic signed [COEF_W+Y_W-1:0] prod_c;
    logic signed [ACC_W-1:0]      acc;
    logic signed [ACC_W-1:0]      acc_rnd;
    logic signed [RND_W-1:0]      y_wide;

    assign prod_a = coef_a * x;
    assign prod_b = coef_b * h1;
    assign prod_c = coef_c * h2;

    assign acc = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(prod_c);

    // round half up, then drop the fraction
    assign acc_rnd = acc + (ACC_W'(1) <<< (Q_SHIFT - 1));
    assign y_wide  = acc_rnd[ACC_W-1:Q_SHIFT];

    always_comb
    begin
        if (y_wide > RND_W'(OUT_MAX))
        begin
            res.sample  = OUT_MAX;
            res.clipped = 1'b1;
        end
        else if (y_wide < RND_W'(OUT_MIN))
        begin
            res.sample  = OUT_MIN;
            res.clipped = 1'b1;
        end
        else
        begin
            res.sample  = y_wide[Y_W-1:0];
            res.clipped = 1'b0;
        end
    end

endmodule

// ===== rtl/core/formant_resonator_section.sv =====
// Second-order formant section: y = a*x + b*h1 + c*h2 with Q8.24 coefficients, rounded
// half up and saturated to 24 bits (clipped flags saturation). The block takes one
// sample per clock unless in_stall is raised: a beat lands in an input register, the
// three multiplies, the sum and the rounding are combinational into the output register,
// and the history feeds back from that same compute step, so throughput is one beat per
// cycle while the output side is not stalled. Coefficient and mode registers are written
// through the cfg port (always ready); the init values reach the running coefficients
// only on a beat with reload set, which also clears the history before that sample.
// With ramp_on set, the running coefficients step by step_a/b/c after each sample.
module formant_resonator_section (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  frs_pkg::smp_in_t            sample_in,
    input  logic                        reload,

    output logic                        out_valid,
    input  logic                        out_stall,
    output frs_pkg::smp_out_t           sample_out,
    output logic                        clipped,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [frs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [31:0]                 cfg_data
);
    import frs_pkg::*;

    coef_t init_a_reg, init_b_reg, init_c_reg;
    coef_t step_a_reg, step_b_reg, step_c_reg;
    logic  anti_mode_reg, ramp_on_reg;

    coef_t    run_a_reg, run_b_reg, run_c_reg;
    coef_t    run_a_next, run_b_next, run_c_next;
    smp_out_t hist_one_reg, hist_two_reg;
    smp_out_t hist_one_next, hist_two_next;

    logic    in_valid_reg, in_valid_next;
    smp_in_t in_sample_reg;
    logic    in_reload_reg;

    logic     out_valid_reg, out_valid_next;
    smp_out_t out_sample_reg;
    logic     out_clipped_reg;

    logic        fire;
    coef_t       coef_a, coef_b, coef_c;
    smp_out_t    h1, h2;
    frs_result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_a_reg    <= INIT_A_RST;
            init_b_reg    <= '0;
            init_c_reg    <= '0;
            step_a_reg    <= '0;
            step_b_reg    <= '0;
            step_c_reg    <= '0;
            anti_mode_reg <= 1'b0;
            ramp_on_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INIT_A:    init_a_reg    <= cfg_data;
                REG_INIT_B:    init_b_reg    <= cfg_data;
                REG_INIT_C:    init_c_reg    <= cfg_data;
                REG_STEP_A:    step_a_reg    <= cfg_data;
                REG_STEP_B:    step_b_reg    <= cfg_data;
                REG_STEP_C:    step_c_reg    <= cfg_data;
                REG_ANTI_MODE: anti_mode_reg <= cfg_data[0];
                REG_RAMP_ON:   ramp_on_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // compute stage fires when the output slot is free or draining this cycle
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
            in_valid_next = in_valid;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // reload substitutes init values and a cleared history for this sample
    always_comb
    begin
        if (in_reload_reg)
        begin
            coef_a = init_a_reg;
            coef_b = init_b_reg;
            coef_c = init_c_reg;
            h1     = '0;
            h2     = '0;
        end
        else
        begin
            coef_a = run_a_reg;
            coef_b = run_b_reg;
            coef_c = run_c_reg;
            h1     = hist_one_reg;
            h2     = hist_two_reg;
        end
    end

    frs_datapath u_datapath (
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .x      (in_sample_reg),
        .h1     (h1),
        .h2     (h2),
        .res    (res)
    );

    always_comb
    begin
        run_a_next    = run_a_reg;
        run_b_next    = run_b_reg;
        run_c_next    = run_c_reg;
        hist_one_next = hist_one_reg;
        hist_two_next = hist_two_reg;
        if (fire)
        begin
            hist_two_next = h1;
            hist_one_next = anti_mode_reg ? Y_W'(in_sample_reg) : res.sample;
            if (ramp_on_reg)
            begin
                run_a_next = coef_a + step_a_reg;
                run_b_next = coef_b + step_b_reg;
                run_c_next = coef_c + step_c_reg;
            end
            else
            begin
                run_a_next = coef_a;
                run_b_next = coef_b;
                run_c_next = coef_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_a_reg     <= INIT_A_RST;
            run_b_reg     <= '0;
            run_c_reg     <= '0;
            hist_one_reg  <= '0;
            hist_two_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            run_a_reg     <= run_a_next;
            run_b_reg     <= run_b_next;
            run_c_reg     <= run_c_next;
            hist_one_reg  <= hist_one_next;
            hist_two_reg  <= hist_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_sample_reg <= sample_in;
            in_reload_reg <= reload;
        end
        if (fire)
        begin
            out_sample_reg  <= res.sample;
            out_clipped_reg <= res.clipped;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign clipped    = out_clipped_reg;

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_clipped_reg |->
            (out_sample_reg == OUT_MAX || out_sample_reg == OUT_MIN))
        else $error("clipped beat not at a rail");

    a_reload_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reload_reg |=> hist_two_reg == '0)
        else $error("history not cleared on reload");

    a_anti_hist: assert property (@(posedge clk) disable iff (!rst_n)
        fire && anti_mode_reg |=> hist_one_reg == Y_W'($past(in_sample_reg)))
        else $error("antiresonator history did not take the input");

    a_coef_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(run_a_reg) && $stable(hist_one_reg))
        else $error("state moved without a sample");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with an empty output slot");

endmodule
